>>> hw/rtl/step_sequencer_position_macros.svh
// ----------------------------------------------------------------------------
// Step sequencer position assertion macros
// Shorthands for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCER_POSITION_MACROS_SVH
`define STEP_SEQUENCER_POSITION_MACROS_SVH

// same-cycle implication
`define SSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Step sequencer position package
// Register map, reset values, sequencer states and pattern helper.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int NUM_STEPS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INCREMENT_BY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_PAT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOOPS_PER    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_PERCENT = 3'd7;

  // reset values
  localparam logic [4:0] RST_STRIDE       = 5'd1;
  localparam logic [4:0] RST_WIN_LEN      = 5'd16;
  localparam logic [2:0] RST_PAT_COUNT    = 3'd1;
  localparam logic [7:0] RST_LOOPS_PER    = 8'd1;
  localparam logic [6:0] RST_PLAY_PERCENT = 7'd100;

  localparam logic signed [8:0] WRAP_SPAN = 9'sd16;
  localparam logic [2:0] MAX_FIXES = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_MOVE,
    ST_EDGE,
    ST_FIX,
    ST_WIN,
    ST_DIV,
    ST_DONE
  } ssp_state_e;

  // (p + 1) mod n, kept to two bits, for p < 4 and 2 <= n <= 7: two compare-subtract steps suffice
  function automatic logic [1:0] pat_next(input logic [1:0] p, input logic [2:0] n);
    logic [2:0] v;
    v = {1'b0, p} + 3'd1;
    if (v >= n) v = v - n;
    if (v >= n) v = v - n;
    return v[1:0];
  endfunction

endpackage

>>> hw/rtl/step_sequencer_position.sv
// ----------------------------------------------------------------------------
// Step sequencer position engine
// Per tick: IDLE accepts it and LOOP updates loop and pattern state; a tick that
// does not run (inactive or not started) then goes to DONE. A running tick on a
// boundary passes MOVE, EDGE, FIX (up to MAX_FIXES wrap corrections) and WIN;
// any running tick takes DIV_STEPS = clog2(255 / TICKS_PER_STEP + 1) steps in DIV
// (1 at 240 ticks, 0 above 255). DONE waits out any output stall, then goes to IDLE.
// One shared 9-bit add/subtract unit does the step move, corrections, window
// shift and offset reduction. Async active-low reset clears configuration and
// control state and cnt; tick payload, cur, rem and output data are not reset.
// ----------------------------------------------------------------------------
`include "step_sequencer_position_macros.svh"

module step_sequencer_position import ssp_pkg::*; #(
  parameter int TICKS_PER_STEP = 240,
  parameter int MAX_PATTERNS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // tick input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // tick_in_step[7:0], random_percent[14:8]
  input  logic [2:0]            s_axis_tuser,  // is_loop_start, is_step_boundary, generator_active
  // position output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // step_out[3:0], pattern_out[5:4], event_slot[17:6]
  output logic [1:0]            m_axis_tuser   // fire, play_allowed
);

  localparam int DIV_STEPS = (TICKS_PER_STEP > 255) ? 0 : $clog2(255 / TICKS_PER_STEP + 1);
  localparam bit HAS_DIV = (DIV_STEPS > 0);
  localparam logic [2:0] DIV_TOP = (DIV_STEPS > 0) ? 3'(DIV_STEPS - 1) : 3'd0;
  localparam logic [8:0] TPS_DIV = 9'(TICKS_PER_STEP);
  localparam logic [2:0] PAT_LIMIT = (MAX_PATTERNS > 7) ? 3'd7 : 3'(MAX_PATTERNS);
  localparam int SLOT_W = $clog2(NUM_STEPS * TICKS_PER_STEP) + 1;

  // configuration
  logic [4:0] stride_q;
  logic       fold_q;
  logic [4:0] range_q;
  logic [4:0] incr_q;
  logic       multi_q;
  logic [2:0] pcount_q;
  logic [7:0] loops_per_q;
  logic [6:0] play_pct_q;

  // sequencer state
  ssp_state_e state_q, state_d;
  logic       started_q, started_d;
  logic [3:0] pos_q, pos_d;
  logic       back_q, back_d;
  logic [3:0] wstart_q, wstart_d;
  logic [3:0] wcnt_q, wcnt_d;
  logic [1:0] pat_q, pat_d;
  logic [7:0] loops_q, loops_d;

  // current tick
  logic       loop_q, loop_d;
  logic       bound_q, bound_d;
  logic       active_q, active_d;
  logic [7:0] tick_q, tick_d;
  logic [6:0] rnd_q, rnd_d;

  // work registers
  logic signed [8:0] cur_q, cur_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [7:0]        rem_q, rem_d;

  // output register
  logic        m_valid_q, m_valid_d;
  logic [23:0] out_data_q, out_data_d;
  logic [1:0]  out_user_q, out_user_d;

  // shared adder
  logic signed [8:0] alu_a, alu_b, alu_res;
  logic              alu_sub;

  logic [4:0]  eff_len;
  logic [2:0]  pat_n;
  logic        run;
  logic        in_xfer;
  logic        out_room;
  logic        fix_more;
  logic        win_full;
  logic [8:0]  div_wide;
  logic signed [8:0] rs_s, len_s, end_s, over_amt, near_s, far_s, edge_cur;
  logic        under, overf;
  logic        fire;
  logic [SLOT_W-1:0] slot_full;
  logic [11:0] slot;

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {8'd0, alu_sub};

  assign eff_len = (range_q == 5'd0) ? 5'd1 : ((range_q > 5'd16) ? 5'd16 : range_q);
  assign pat_n = (pcount_q > PAT_LIMIT) ? PAT_LIMIT : pcount_q;
  assign run = active_q && (started_q || loop_q);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign out_room = !m_valid_q || m_axis_tready;
  assign fix_more = ((cur_q >= WRAP_SPAN) || (cur_q < 9'sd0)) && (cnt_q < MAX_FIXES);
  assign win_full = (({1'b0, wcnt_q} + 5'd1) >= eff_len);
  assign div_wide = TPS_DIV << cnt_q;

  // window edge handling: fold reflects, wrap re-enters from the other side
  assign rs_s = $signed({5'd0, wstart_q});
  assign len_s = $signed({4'd0, eff_len});
  assign end_s = rs_s + len_s;
  assign under = (cur_q < rs_s) || (cur_q < 9'sd0);
  assign overf = (cur_q >= WRAP_SPAN) || (cur_q >= end_s);
  assign over_amt = under ? (rs_s - cur_q)
                  : ((cur_q >= WRAP_SPAN) ? (cur_q - WRAP_SPAN) : (cur_q - end_s));
  assign near_s = rs_s + over_amt;
  assign far_s = end_s - over_amt - 9'sd1;
  assign edge_cur = under ? (fold_q ? near_s : far_s)
                  : (overf ? (fold_q ? far_s : near_s) : cur_q);

  assign fire = active_q && started_q;
  assign slot_full = SLOT_W'(pos_q) * SLOT_W'(TICKS_PER_STEP) + SLOT_W'(rem_q);
  assign slot = fire ? 12'(slot_full) : 12'd0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_LOOP;
      ST_LOOP: begin
        if (run && bound_q) state_d = ST_MOVE;
        else if (run && HAS_DIV) state_d = ST_DIV;
        else state_d = ST_DONE;
      end
      ST_MOVE: state_d = ST_EDGE;
      ST_EDGE: state_d = ST_FIX;
      ST_FIX:  if (!fix_more) state_d = ST_WIN;
      ST_WIN:  state_d = HAS_DIV ? ST_DIV : ST_DONE;
      ST_DIV:  if (cnt_q == 3'd0) state_d = ST_DONE;
      ST_DONE: if (out_room) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs and adder operands
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    alu_a = 9'sd0;
    alu_b = 9'sd0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_MOVE: begin
        alu_a = $signed({5'd0, pos_q});
        alu_b = $signed({4'd0, stride_q});
        alu_sub = back_q;
      end
      ST_FIX: begin
        alu_a = cur_q;
        alu_b = WRAP_SPAN;
        alu_sub = !cur_q[8];
      end
      ST_WIN: begin
        alu_a = $signed({5'd0, wstart_q});
        alu_b = $signed({{4{incr_q[4]}}, incr_q});
      end
      ST_DIV: begin
        alu_a = $signed({1'b0, rem_q});
        alu_b = $signed(div_wide);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    started_d = started_q;
    pos_d = pos_q;
    back_d = back_q;
    wstart_d = wstart_q;
    wcnt_d = wcnt_q;
    pat_d = pat_q;
    loops_d = loops_q;
    loop_d = loop_q;
    bound_d = bound_q;
    active_d = active_q;
    tick_d = tick_q;
    rnd_d = rnd_q;
    cur_d = cur_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          tick_d = s_axis_tdata[7:0];
          rnd_d = s_axis_tdata[14:8];
          loop_d = s_axis_tuser[0];
          bound_d = s_axis_tuser[1];
          active_d = s_axis_tuser[2];
        end
      end
      ST_LOOP: begin
        if (active_q && loop_q) begin
          started_d = 1'b1;
          if (multi_q && (pat_n > 3'd1)) begin
            if (loops_q <= 8'd1) begin
              pat_d = pat_next(pat_q, pat_n);
              loops_d = loops_per_q;
            end else begin
              loops_d = loops_q - 8'd1;
            end
          end
        end
        rem_d = tick_q;
        cnt_d = DIV_TOP;
      end
      ST_MOVE: cur_d = alu_res;
      ST_EDGE: begin
        cur_d = edge_cur;
        if (fold_q && under) back_d = 1'b0;
        else if (fold_q && overf) back_d = 1'b1;
        cnt_d = 3'd0;
      end
      ST_FIX: begin
        if (fix_more) begin
          cur_d = alu_res;
          cnt_d = cnt_q + 3'd1;
        end else begin
          pos_d = cur_q[3:0];
        end
      end
      ST_WIN: begin
        if (win_full) begin
          wcnt_d = 4'd0;
          wstart_d = alu_res[3:0];
        end else begin
          wcnt_d = wcnt_q + 4'd1;
        end
        cnt_d = DIV_TOP;
      end
      ST_DIV: begin
        if (!alu_res[8]) rem_d = alu_res[7:0];
        if (cnt_q != 3'd0) cnt_d = cnt_q - 3'd1;
      end
      ST_DONE: begin
        if (out_room) begin
          m_valid_d = 1'b1;
          out_data_d = {6'd0, slot, pat_q, pos_q};
          out_user_d = {fire && (rnd_q < play_pct_q), fire};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= RST_STRIDE;
      fold_q <= 1'b0;
      range_q <= RST_WIN_LEN;
      incr_q <= 5'd0;
      multi_q <= 1'b0;
      pcount_q <= RST_PAT_COUNT;
      loops_per_q <= RST_LOOPS_PER;
      play_pct_q <= RST_PLAY_PERCENT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STRIDE:       stride_q <= cfg_wdata_i[4:0];
        REG_FOLD_ENABLE:  fold_q <= cfg_wdata_i[0];
        REG_WIN_LEN:      range_q <= cfg_wdata_i[4:0];
        REG_INCREMENT_BY: incr_q <= cfg_wdata_i[4:0];
        REG_MULTI_PAT:    multi_q <= cfg_wdata_i[0];
        REG_PAT_COUNT:    pcount_q <= cfg_wdata_i[2:0];
        REG_LOOPS_PER:    loops_per_q <= cfg_wdata_i;
        REG_PLAY_PERCENT: play_pct_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      started_q <= 1'b0;
      pos_q <= 4'd0;
      back_q <= 1'b0;
      wstart_q <= 4'd0;
      wcnt_q <= 4'd0;
      pat_q <= 2'd0;
      loops_q <= 8'd0;
      cnt_q <= 3'd0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      started_q <= started_d;
      pos_q <= pos_d;
      back_q <= back_d;
      wstart_q <= wstart_d;
      wcnt_q <= wcnt_d;
      pat_q <= pat_d;
      loops_q <= loops_d;
      cnt_q <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    loop_q <= loop_d;
    bound_q <= bound_d;
    active_q <= active_d;
    tick_q <= tick_d;
    rnd_q <= rnd_d;
    cur_q <= cur_d;
    rem_q <= rem_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;

  `SSP_ASSERT_NXT(a_xfer_starts_seq, s_axis_tvalid && s_axis_tready, state_q == ST_LOOP, "tick transfer did not start the sequencer")
  `SSP_ASSERT_IMP(a_fix_bounded, state_q == ST_FIX, cnt_q <= MAX_FIXES, "more than five wrap corrections")
  `SSP_ASSERT_IMP(a_quiet_no_fire, m_axis_tvalid && !m_axis_tuser[0], (m_axis_tdata[17:6] == 12'd0) && !m_axis_tuser[1], "slot or play set without fire")

endmodule
